// File: hdl/tet4_pkg.sv
// Shared types, codes and saturation helpers of the tetrahedron stiffness unit.
`default_nettype none

package tet4_pkg;

    localparam int NUM_NODES  = 4;
    localparam int DIMS       = 3;
    localparam int GRAD_CNT   = NUM_NODES * DIMS;
    localparam int ENTRY_CNT  = DIMS * DIMS;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 584;

    localparam logic [1:0] NODE_EMIT  = 2'd3;
    localparam logic [1:0] DIM_LAST   = 2'd2;

    localparam logic [1:0] CFG_SHEAR  = 2'd0;
    localparam logic [1:0] CFG_LAMBDA = 2'd1;
    localparam logic [1:0] CFG_WDEV   = 2'd2;
    localparam logic [1:0] CFG_WLAM   = 2'd3;

    typedef struct packed {
        logic [31:0] shear;
        logic [31:0] lambda;
        logic [31:0] wdev;
        logic [31:0] wlam;
    } cfg_t;

    typedef struct packed {
        logic [31:0]                det;
        logic [GRAD_CNT-1:0][31:0]  grad;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_PROD,
        S_TDEV,
        S_TLAM,
        S_OUT
    } bstate_t;

    function automatic logic signed [63:0] sext32(input logic [31:0] v);
        sext32 = {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [127:0] sext64(input logic [63:0] v);
        sext64 = {{64{v[63]}}, v};
    endfunction

    // Clamp a wide signed value to the signed 64-bit range.
    function automatic logic [63:0] sat128(input logic [127:0] v);
        if (v[127:63] == {65{1'b0}} || v[127:63] == {65{1'b1}})
            sat128 = v[63:0];
        else if (v[127])
            sat128 = {1'b1, {63{1'b0}}};
        else
            sat128 = {1'b0, {63{1'b1}}};
    endfunction

    // Flat index of component d of node n (or of entry row n, column d).
    function automatic logic [3:0] gidx(input logic [1:0] n, input logic [1:0] d);
        gidx = ({2'b00, n} << 1) + {2'b00, n} + {2'b00, d};
    endfunction

endpackage

`default_nettype wire

// File: hdl/tet4_front.sv
// Front end: accepts gradient words, keeps the gradient store and issues emission commands.
`default_nettype none

module tet4_front
    import tet4_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 q_full,
    output logic                      push,
    output cmd_t                      cmd
);

    logic [GRAD_CNT-1:0][31:0] g_reg;
    logic [GRAD_CNT-1:0][31:0] g_next;
    logic [1:0]                node;
    logic                      accept;

    assign node     = s_tdata[1:0];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        g_next = g_reg;
        g_next[gidx(node, 2'd0)] = s_tdata[33:2];
        g_next[gidx(node, 2'd1)] = s_tdata[65:34];
        g_next[gidx(node, 2'd2)] = s_tdata[97:66];
    end

    // Only the determinant of the node-3 word reaches an emission, so it
    // travels with the command instead of being kept here.
    assign push     = accept && (node == NODE_EMIT);
    assign cmd.det  = s_tdata[129:98];
    assign cmd.grad = g_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= '0;
        end
        else if (accept)
        begin
            g_reg <= g_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tet4_queue.sv
// Two-entry command queue between the front end and the compute sequencer.
`default_nettype none

module tet4_queue
    import tet4_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      head
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tet4_rsmul.sv
// Shared multiplier: 64x64 signed product in four 33x33 partials, optional rounding shift.
`default_nettype none

module tet4_rsmul
    import tet4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               rnd,
    input  wire logic signed [63:0] x,
    input  wire logic signed [63:0] y,
    output logic                    done,
    output logic [63:0]             res
);

    logic                busy_reg;
    logic [2:0]          cnt_reg;
    logic                done_reg;
    logic                rnd_reg;
    logic [63:0]         x_reg;
    logic [63:0]         y_reg;
    logic signed [65:0]  prod_reg;
    logic [1:0]          part_reg;
    logic signed [127:0] acc_reg;
    logic [63:0]         res_reg;

    logic signed [32:0]  a33;
    logic signed [32:0]  b33;
    logic signed [65:0]  prod_next;
    logic signed [127:0] prod_ext;
    logic signed [127:0] addend;
    logic signed [127:0] rounded;
    logic signed [127:0] shifted;

    // Partial order: low*low, low*high, high*low, high*high.
    assign a33 = cnt_reg[1] ? {x_reg[63], x_reg[63:32]} : {1'b0, x_reg[31:0]};
    assign b33 = cnt_reg[0] ? {y_reg[63], y_reg[63:32]} : {1'b0, y_reg[31:0]};
    assign prod_next = a33 * b33;
    assign prod_ext  = {{62{prod_reg[65]}}, prod_reg};

    always_comb
    begin
        case (part_reg)
            2'd0:    addend = prod_ext;
            2'd3:    addend = prod_ext <<< 64;
            default: addend = prod_ext <<< 32;
        endcase
    end

    assign rounded = acc_reg + (128'sd1 <<< (FRAC_BITS - 1));
    assign shifted = rounded >>> FRAC_BITS;

    assign done = done_reg;
    assign res  = res_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            rnd_reg <= rnd;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                prod_reg <= prod_next;
                part_reg <= cnt_reg[1:0];
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                acc_reg <= acc_reg + addend;
            if (cnt_reg == 3'd5)
                res_reg <= rnd_reg ? sat128(shifted) : acc_reg[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/tet4_back.sv
// Back end: sequences coefficient, product and block-entry operations and holds the output word.
`default_nettype none

module tet4_back
    import tet4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  cfg_t                       cfg,
    input  wire logic                  q_valid,
    input  cmd_t                       q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast
);

    bstate_t state_reg;
    bstate_t state_next;
    logic    wait_reg;

    logic [GRAD_CNT-1:0][31:0]  g_reg;
    logic [31:0]                det_reg;
    logic [63:0]                tmp_reg;
    logic [63:0]                cdev_reg;
    logic [63:0]                clam_reg;
    logic [ENTRY_CNT-1:0][63:0] pm_reg;
    logic [63:0]                tdev_reg;
    logic [ENTRY_CNT-1:0][63:0] k_reg;
    logic [1:0]                 p_reg;
    logic [1:0]                 q_reg;
    logic [1:0]                 i_reg;
    logic [1:0]                 j_reg;

    logic                       out_valid_reg;
    logic [1:0]                 out_row_reg;
    logic [1:0]                 out_col_reg;
    logic [ENTRY_CNT-1:0][63:0] out_k_reg;
    logic                       out_last_reg;

    logic               mul_start;
    logic               mul_rnd;
    logic signed [63:0] mul_x;
    logic signed [63:0] mul_y;
    logic               mul_done;
    logic [63:0]        mul_res;

    logic               op_state;
    logic               entry_last;
    logic               block_last;
    logic               out_free;
    logic [63:0]        sdev;
    logic [127:0]       diag_sum;
    logic [63:0]        tsum;

    tet4_rsmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rsmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .rnd   (mul_rnd),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign entry_last = (p_reg == DIM_LAST) && (q_reg == DIM_LAST);
    assign block_last = (i_reg == NODE_EMIT) && (j_reg == NODE_EMIT);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        case (state_reg)
            S_C1, S_C2, S_C3, S_C4, S_PROD, S_TDEV, S_TLAM: op_state = 1'b1;
            default:                                        op_state = 1'b0;
        endcase
    end

    // Deviatoric sum: trace plus the diagonal product, or the transposed cross product.
    assign diag_sum = sext64(pm_reg[gidx(2'd0, 2'd0)]) + sext64(pm_reg[gidx(2'd1, 2'd1)])
                    + sext64(pm_reg[gidx(2'd2, 2'd2)]) + sext64(pm_reg[gidx(p_reg, p_reg)]);
    assign sdev = (p_reg == q_reg) ? sat128(diag_sum) : pm_reg[gidx(q_reg, p_reg)];
    assign tsum = sat128(sext64(tdev_reg) + sext64(mul_res));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_C1;
            S_C1:   if (wait_reg && mul_done) state_next = S_C2;
            S_C2:   if (wait_reg && mul_done) state_next = S_C3;
            S_C3:   if (wait_reg && mul_done) state_next = S_C4;
            S_C4:   if (wait_reg && mul_done) state_next = S_PROD;
            S_PROD: if (wait_reg && mul_done && entry_last) state_next = S_TDEV;
            S_TDEV: if (wait_reg && mul_done) state_next = S_TLAM;
            S_TLAM:
            begin
                if (wait_reg && mul_done)
                    state_next = entry_last ? S_OUT : S_TDEV;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = block_last ? S_IDLE : S_PROD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Multiplier operands and queue pop.
    always_comb
    begin
        q_pop     = (state_reg == S_IDLE) && q_valid;
        mul_start = op_state && !wait_reg;
        mul_rnd   = 1'b1;
        mul_x     = '0;
        mul_y     = '0;
        case (state_reg)
            S_C1:
            begin
                mul_x = {32'd0, cfg.shear};
                mul_y = sext32(det_reg);
            end
            S_C2:
            begin
                mul_x = tmp_reg;
                mul_y = {32'd0, cfg.wdev};
            end
            S_C3:
            begin
                mul_x = {32'd0, cfg.lambda};
                mul_y = sext32(det_reg);
            end
            S_C4:
            begin
                mul_x = tmp_reg;
                mul_y = {32'd0, cfg.wlam};
            end
            S_PROD:
            begin
                mul_rnd = 1'b0;
                mul_x   = sext32(g_reg[gidx(i_reg, p_reg)]);
                mul_y   = sext32(g_reg[gidx(j_reg, q_reg)]);
            end
            S_TDEV:
            begin
                mul_x = cdev_reg;
                mul_y = sdev;
            end
            S_TLAM:
            begin
                mul_x = clam_reg;
                mul_y = pm_reg[gidx(p_reg, q_reg)];
            end
            default:
            begin
                mul_rnd = 1'b1;
            end
        endcase
    end

    // Datapath captures.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            g_reg   <= q_head.grad;
            det_reg <= q_head.det;
        end
        if (wait_reg && mul_done)
        begin
            case (state_reg)
                S_C1, S_C3: tmp_reg  <= mul_res;
                S_C2:       cdev_reg <= mul_res;
                S_C4:       clam_reg <= mul_res;
                S_PROD:     pm_reg[gidx(p_reg, q_reg)] <= mul_res;
                S_TDEV:     tdev_reg <= mul_res;
                S_TLAM:     k_reg[gidx(p_reg, q_reg)] <= tsum;
                default:    tmp_reg  <= tmp_reg;
            endcase
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_k_reg    <= k_reg;
            out_last_reg <= block_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            p_reg         <= 2'd0;
            q_reg         <= 2'd0;
            i_reg         <= 2'd0;
            j_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
                wait_reg <= 1'b1;
            else if (mul_done)
                wait_reg <= 1'b0;

            if (q_pop)
            begin
                i_reg <= 2'd0;
                j_reg <= 2'd0;
                p_reg <= 2'd0;
                q_reg <= 2'd0;
            end
            else if (wait_reg && mul_done && (state_reg == S_PROD || state_reg == S_TLAM))
            begin
                if (q_reg == DIM_LAST)
                begin
                    q_reg <= 2'd0;
                    p_reg <= (p_reg == DIM_LAST) ? 2'd0 : p_reg + 2'd1;
                end
                else
                    q_reg <= q_reg + 2'd1;
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                j_reg <= j_reg + 2'd1;
                if (j_reg == NODE_EMIT)
                    i_reg <= i_reg + 2'd1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_k_reg[8], out_k_reg[7], out_k_reg[6], out_k_reg[5],
                       out_k_reg[4], out_k_reg[3], out_k_reg[2], out_k_reg[1],
                       out_k_reg[0], out_col_reg, out_row_reg};

endmodule

`default_nettype wire

// File: hdl/tet4_elasticity_element_stiffness_unit.sv
// Top level of the P1 tetrahedron elasticity element stiffness unit.
// All operations share the single 33x33 multiplier (each operation is four partials).
// Words for nodes 0..2 are taken whenever the queue is not full; a two-entry queue
// holds pending elements. Reset (rst_n, asynchronous, active low) zeroes the
// gradient store and sets all four registers to one.
`default_nettype none

module tet4_elasticity_element_stiffness_unit
    import tet4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // APB configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Input word: node[1:0], grad_x[33:2], grad_y[65:34], grad_z[97:66],
    // jacobian_det[129:98], zero fill to bit 135.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // Output word: block_row[1:0], block_col[3:2], k_xx[67:4], k_xy[131:68],
    // k_xz[195:132], k_yx[259:196], k_yy[323:260], k_yz[387:324],
    // k_zx[451:388], k_zy[515:452], k_zz[579:516], zero fill to bit 583.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    cfg_t cfg_reg;
    logic cfg_wr;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Registers are written during the access phase; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shear  <= ONE;
            cfg_reg.lambda <= ONE;
            cfg_reg.wdev   <= ONE;
            cfg_reg.wlam   <= ONE;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                CFG_SHEAR:  cfg_reg.shear  <= pwdata;
                CFG_LAMBDA: cfg_reg.lambda <= pwdata;
                CFG_WDEV:   cfg_reg.wdev   <= pwdata;
                CFG_WLAM:   cfg_reg.wlam   <= pwdata;
                default:    cfg_reg.shear  <= cfg_reg.shear;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            CFG_SHEAR:  prdata = cfg_reg.shear;
            CFG_LAMBDA: prdata = cfg_reg.lambda;
            CFG_WDEV:   prdata = cfg_reg.wdev;
            CFG_WLAM:   prdata = cfg_reg.wlam;
            default:    prdata = '0;
        endcase
    end

    // The front end stores gradients and snapshots the whole element on node 3,
    // so later words can overwrite the store while the back end still computes.
    tet4_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    tet4_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    // The back end forms both coefficients, then for each of the sixteen
    // blocks the nine gradient products and the eighteen scaled terms.
    tet4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
